// File: rtl/power_window_antipinch_controller_macros.svh
`ifndef POWER_WINDOW_ANTIPINCH_CONTROLLER_MACROS_SVH
`define POWER_WINDOW_ANTIPINCH_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PWAC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwac: assertion failed");

// Next-cycle implication, checked outside reset.
`define PWAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwac: assertion failed");

`endif

// File: rtl/pwac_pkg.sv
package pwac_pkg;

    localparam int SPC       = 10;
    localparam int SUM_W     = 16;
    localparam int IDX_W     = $clog2(SPC + 1);
    localparam int DIV_SHIFT = SUM_W + $clog2(SPC);
    localparam int RECIP_W   = SUM_W + 1;
    // ceil(2^DIV_SHIFT / SPC) gives an exact quotient for every SUM_W-bit sum
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(SPC) - 64'd1) / 64'(SPC));

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_DOWN_PRESS = 3'd1;
    localparam logic [2:0] PH_AUTO_DOWN  = 3'd2;
    localparam logic [2:0] PH_UP_PRESS   = 3'd3;
    localparam logic [2:0] PH_AUTO_UP    = 3'd4;
    localparam logic [2:0] PH_REVERSE    = 3'd5;
    localparam logic [2:0] PH_WAIT       = 3'd6;

    typedef enum logic [2:0] {
        CFG_DEBOUNCE  = 3'd0,
        CFG_LONG      = 3'd1,
        CFG_CANCEL    = 3'd2,
        CFG_REVERSE   = 3'd3,
        CFG_BLANK     = 3'd4,
        CFG_TRIP_LOW  = 3'd5,
        CFG_TRIP_HIGH = 3'd6
    } t_cfg_idx;

    typedef enum logic [6:0] {
        S_IDLE       = 7'b0000001,
        S_DOWN_PRESS = 7'b0000010,
        S_AUTO_DOWN  = 7'b0000100,
        S_UP_PRESS   = 7'b0001000,
        S_AUTO_UP    = 7'b0010000,
        S_REVERSE    = 7'b0100000,
        S_WAIT       = 7'b1000000
    } t_state;

    typedef struct packed {
        logic        func;
        logic        down_switch;
        logic        up_switch;
        logic        down_limit;
        logic        up_limit;
        logic [11:0] current_code;
    } t_in_item;

    typedef struct packed {
        logic       relay_down_on;
        logic       relay_up_on;
        logic [2:0] phase;
        logic       pinch_trip;
    } t_out_item;

    function automatic logic [2:0] phase_code(t_state s);
        logic [2:0] p;
        unique case (s)
            S_IDLE:       p = PH_IDLE;
            S_DOWN_PRESS: p = PH_DOWN_PRESS;
            S_AUTO_DOWN:  p = PH_AUTO_DOWN;
            S_UP_PRESS:   p = PH_UP_PRESS;
            S_AUTO_UP:    p = PH_AUTO_UP;
            S_REVERSE:    p = PH_REVERSE;
            S_WAIT:       p = PH_WAIT;
            default:      p = PH_IDLE;
        endcase
        return p;
    endfunction

endpackage

// File: rtl/power_window_antipinch_controller.sv
// Power window lift controller with anti-pinch reversal.
// Input channel (i_in_valid / o_in_stall, payload i_in_data): each transfer is
// either a 1 ms tick with the switch and limit levels (func 0) or one 12-bit
// current sample (func 1). Output channel (o_out_valid / i_out_stall, payload
// o_out_data): exactly one result per input transfer, in order, giving the
// relay drive, the phase and the anti-pinch trip flag after that item.
// The state and the result register update at the edge that takes the input.
// Throughput is one item per cycle while the receiver does not stall; the
// single result register sets it, and the next item is taken in the same
// cycle that the held result is transferred.
// While the receiver stalls, the result register holds and o_in_stall is
// raised, so no input is taken until the result goes out.
// Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data at the
// clock edge; indexes past the last register are ignored. Write only while
// no item is in flight.
// Reset (synchronous, i_rst_n low) returns to idle with no result valid, clears
// all counters and loads the default timings and trip codes.
`include "power_window_antipinch_controller_macros.svh"

module power_window_antipinch_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pwac_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pwac_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [11:0]         i_cfg_data
);
    import pwac_pkg::*;

    // configuration
    logic [7:0]  r_debounce;
    logic [11:0] r_long;
    logic [7:0]  r_cancel_ms;
    logic [9:0]  r_reverse;
    logic [7:0]  r_blank_ms;
    logic [11:0] r_trip_low;
    logic [11:0] r_trip_high;

    // control state
    t_state           r_state, n_state;
    logic [11:0]      r_hold, n_hold;
    logic [7:0]       r_cancel, n_cancel;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [7:0]       r_blank, n_blank;
    logic             r_dead, n_dead;
    logic [7:0]       r_deb, n_deb;
    logic             r_wait_up, n_wait_up;

    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    logic accept;

    // helpers
    logic                     dsw, usw, dlim, ulim;
    logic                     motion;
    logic                     p_sw, p_lim;
    t_state                   p_motion;
    logic [11:0]              hold_sat;
    logic                     opp;
    logic [7:0]               c_deb, c_cnt;
    logic                     c_hit;
    logic [SUM_W:0]           sum_ext;
    logic [SUM_W-1:0]         sum_new;
    logic [IDX_W-1:0]         idx_new;
    logic [SUM_W+RECIP_W-1:0] prod;
    logic [SUM_W-1:0]         avg;
    logic                     sample_ok;
    logic                     trip;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_out_valid && i_out_stall;

    assign dsw  = i_in_data.down_switch;
    assign usw  = i_in_data.up_switch;
    assign dlim = i_in_data.down_limit;
    assign ulim = i_in_data.up_limit;

    assign motion = (r_state == S_AUTO_DOWN) || (r_state == S_AUTO_UP) ||
                    (r_state == S_REVERSE);

    assign p_sw     = (r_state == S_DOWN_PRESS) ? dsw : usw;
    assign p_lim    = (r_state == S_DOWN_PRESS) ? dlim : ulim;
    assign p_motion = (r_state == S_DOWN_PRESS) ? S_AUTO_DOWN : S_AUTO_UP;
    assign hold_sat = (r_hold == 12'hFFF) ? r_hold : r_hold + 12'd1;

    // opposite switch debounce and cancel timing during auto motion
    assign opp = (r_state == S_AUTO_UP) ? dsw : usw;
    always_comb begin
        c_deb = r_deb;
        c_cnt = r_cancel;
        c_hit = 1'b0;
        if (!opp) begin
            c_deb = '0;
            c_cnt = '0;
        end else if (r_deb < r_debounce) begin
            c_deb = r_deb + 8'd1;
        end else begin
            c_cnt = (r_cancel == 8'hFF) ? r_cancel : r_cancel + 8'd1;
            c_hit = c_cnt > r_cancel_ms;
        end
    end

    // current averaging: divide by the group size through a reciprocal
    assign sum_ext   = {1'b0, r_sum} + (SUM_W + 1)'(i_in_data.current_code);
    assign sum_new   = sum_ext[SUM_W-1:0];
    assign idx_new   = r_idx + IDX_W'(1);
    assign prod      = sum_new * DIV_RECIP;
    assign avg       = SUM_W'(prod[SUM_W+RECIP_W-1:DIV_SHIFT]);
    assign sample_ok = (r_state == S_AUTO_UP) && !r_dead && (r_blank >= r_blank_ms);

    always_comb begin
        n_state   = r_state;
        n_hold    = r_hold;
        n_cancel  = r_cancel;
        n_sum     = r_sum;
        n_idx     = r_idx;
        n_blank   = r_blank;
        n_dead    = r_dead;
        n_deb     = r_deb;
        n_wait_up = r_wait_up;
        trip      = 1'b0;

        if (!i_in_data.func) begin
            if (motion && r_dead) begin
                // dead tick: only release the relays' hold-off
                n_dead = 1'b0;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        n_deb  = '0;
                        n_hold = '0;
                        if (dsw) begin
                            n_state = S_DOWN_PRESS;
                        end else if (usw) begin
                            n_state = S_UP_PRESS;
                        end
                    end
                    S_DOWN_PRESS, S_UP_PRESS: begin
                        if (!p_sw) begin
                            n_state = S_IDLE;
                        end else if (r_deb < r_debounce) begin
                            n_deb = r_deb + 8'd1;
                        end else begin
                            n_hold = hold_sat;
                            if (hold_sat > r_long) begin
                                if (p_lim) begin
                                    n_deb  = '0;
                                    n_hold = '0;
                                end else begin
                                    n_state  = p_motion;
                                    n_dead   = 1'b1;
                                    n_deb    = '0;
                                    n_cancel = '0;
                                    n_hold   = '0;
                                    n_blank  = '0;
                                    n_sum    = '0;
                                    n_idx    = '0;
                                end
                            end
                        end
                    end
                    S_AUTO_DOWN: begin
                        if (dlim) begin
                            n_state   = S_WAIT;
                            n_wait_up = 1'b0;
                            n_blank   = '0;
                            n_dead    = 1'b0;
                        end else begin
                            n_deb    = c_deb;
                            n_cancel = c_cnt;
                            if (c_hit) begin
                                n_state   = S_WAIT;
                                n_wait_up = 1'b1;
                                n_blank   = '0;
                                n_dead    = 1'b0;
                            end
                        end
                    end
                    S_AUTO_UP: begin
                        if (ulim) begin
                            n_state   = S_WAIT;
                            n_wait_up = 1'b1;
                            n_blank   = '0;
                            n_dead    = 1'b0;
                        end else begin
                            n_deb    = c_deb;
                            n_cancel = c_cnt;
                            if (c_hit) begin
                                n_state   = S_WAIT;
                                n_wait_up = 1'b0;
                                n_blank   = '0;
                                n_dead    = 1'b0;
                            end else if (r_blank < r_blank_ms) begin
                                n_blank = r_blank + 8'd1;
                            end
                        end
                    end
                    S_REVERSE: begin
                        if (r_hold >= {2'b00, r_reverse}) begin
                            n_state   = S_WAIT;
                            n_wait_up = 1'b1;
                            n_blank   = '0;
                            n_dead    = 1'b0;
                        end else begin
                            n_hold = r_hold + 12'd1;
                        end
                    end
                    S_WAIT: begin
                        if (!(r_wait_up ? usw : dsw)) begin
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
        end else if (sample_ok) begin
            n_sum = sum_new;
            n_idx = idx_new;
            if (idx_new >= IDX_W'(SPC)) begin
                n_sum = '0;
                n_idx = '0;
                if (avg <= SUM_W'(r_trip_low) || avg >= SUM_W'(r_trip_high)) begin
                    // anti-pinch: reverse down after a dead tick
                    n_state  = S_REVERSE;
                    n_dead   = 1'b1;
                    n_deb    = '0;
                    n_cancel = '0;
                    n_hold   = '0;
                    n_blank  = '0;
                    trip     = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_out.relay_down_on = !n_dead &&
                              ((n_state == S_AUTO_DOWN) || (n_state == S_REVERSE));
        n_out.relay_up_on   = !n_dead && (n_state == S_AUTO_UP);
        n_out.phase         = phase_code(n_state);
        n_out.pinch_trip    = trip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= 8'd5;
            r_long      <= 12'd500;
            r_cancel_ms <= 8'd10;
            r_reverse   <= 10'd50;
            r_blank_ms  <= 8'd10;
            r_trip_low  <= 12'd3122;
            r_trip_high <= 12'd3749;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DEBOUNCE:  r_debounce  <= i_cfg_data[7:0];
                CFG_LONG:      r_long      <= i_cfg_data;
                CFG_CANCEL:    r_cancel_ms <= i_cfg_data[7:0];
                CFG_REVERSE:   r_reverse   <= i_cfg_data[9:0];
                CFG_BLANK:     r_blank_ms  <= i_cfg_data[7:0];
                CFG_TRIP_LOW:  r_trip_low  <= i_cfg_data;
                CFG_TRIP_HIGH: r_trip_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hold      <= '0;
            r_cancel    <= '0;
            r_sum       <= '0;
            r_idx       <= '0;
            r_blank     <= '0;
            r_dead      <= 1'b0;
            r_deb       <= '0;
            r_wait_up   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_hold      <= n_hold;
                r_cancel    <= n_cancel;
                r_sum       <= n_sum;
                r_idx       <= n_idx;
                r_blank     <= n_blank;
                r_dead      <= n_dead;
                r_deb       <= n_deb;
                r_wait_up   <= n_wait_up;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result while stalled
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PWAC_ASSERT_IMPL(a_relays_exclusive, i_clk, i_rst_n, o_out_valid,
        !(o_out_data.relay_down_on && o_out_data.relay_up_on))
    `PWAC_ASSERT_IMPL(a_trip_reverses, i_clk, i_rst_n,
        o_out_valid && o_out_data.pinch_trip, o_out_data.phase == PH_REVERSE)
    `PWAC_ASSERT_IMPL(a_dead_relays_off, i_clk, i_rst_n, o_out_valid && r_dead,
        !o_out_data.relay_down_on && !o_out_data.relay_up_on)
    `PWAC_ASSERT_NEXT(a_accept_fills_output, i_clk, i_rst_n, accept, o_out_valid)

endmodule
